### hw/rtl/rrts_pkg.sv
// Package for the round-robin task scheduler.
// Holds sizes, request and task state codes, sequencer states and queue structs.
// No dependencies.
`default_nettype none

package rrts_pkg;

  localparam int TASK_COUNT = 16;
  localparam int TASK_W = $clog2(TASK_COUNT);
  localparam int CNT_W = $clog2(TASK_COUNT + 1);
  localparam logic [15:0] SLICE_RESET = 16'd10;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READY = 2'd1,
    REQ_YIELD = 2'd2,
    REQ_SLEEP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_BLOCKED = 2'd3
  } task_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SLICE,
    S_ROT_RD,
    S_ROT,
    S_OP,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TASK_W-1:0] id;
  } q_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TASK_W-1:0] head_id;
  } q_stat_t;

endpackage

`default_nettype wire

### hw/rtl/rrts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/rrts_queue.sv
// Ready queue of task indexes: head, tail and fill count around one RAM.
// Depends on rrts_pkg and rrts_ram. The head entry appears in the cycle after head moves.
`default_nettype none

module rrts_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rrts_pkg::q_ctrl_t ctrl,
  output rrts_pkg::q_stat_t    stat
);

  logic [rrts_pkg::TASK_W-1:0] head;
  logic [rrts_pkg::TASK_W-1:0] tail;
  logic [rrts_pkg::CNT_W-1:0]  count;
  logic [rrts_pkg::TASK_W-1:0] head_id;

  function automatic logic [rrts_pkg::TASK_W-1:0] wrap_inc(
    input logic [rrts_pkg::TASK_W-1:0] p
  );
    if (p == rrts_pkg::TASK_W'(rrts_pkg::TASK_COUNT - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= wrap_inc(head);
      end
      if (ctrl.push) begin
        tail <= wrap_inc(tail);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  rrts_ram #(
    .WIDTH(rrts_pkg::TASK_W),
    .DEPTH(rrts_pkg::TASK_COUNT)
  ) u_fifo_ram (
    .clk  (clk),
    .we   (ctrl.push),
    .waddr(tail),
    .wdata(ctrl.id),
    .raddr(head),
    .rdata(head_id)
  );

  assign stat.count   = count;
  assign stat.head_id = head_id;

endmodule

`default_nettype wire

### hw/rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler top level: task table, sequencer and slice logic.
// Depends on rrts_pkg, rrts_queue and rrts_ram.
//
// A request is a transaction on start, req_type, task_id, from_user and wake_time.
// It is taken at a rising edge with start high and busy low. Exactly one result
// follows: run_task, run_valid, switched, idle and tick_count are valid for the
// single cycle in which done is high, and the receiver cannot hold them off.
// busy is low again in that same cycle, so a new request may start then.
// A tick walks all task entries through one shared wake-time comparator, one
// entry per cycle behind the wake-time RAM read, and then checks the slice.
// A tick runs S_SCAN and S_SLICE, then S_ROT_RD and S_ROT if the slice runs out;
// a yield runs S_ROT_RD and S_ROT; make-ready and sleep run S_OP. One request is
// in flight at a time. slice_length is written through cfg_wen and cfg_wdata;
// the user must write it only while the block is idle, which the block does not
// enforce. Reset frees all tasks, empties the queue, clears the current task, the
// slice count and the tick counter, and sets slice_length to 10.
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [3:0]  task_id,
  input  wire logic        from_user,
  input  wire logic [63:0] wake_time,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata,
  output logic             done,
  output logic [3:0]       run_task,
  output logic             run_valid,
  output logic             switched,
  output logic             idle,
  output logic [63:0]      tick_count
);

  localparam int TW = rrts_pkg::TASK_W;
  localparam int N = rrts_pkg::TASK_COUNT;
  localparam int SW = rrts_pkg::CNT_W;

  rrts_pkg::seq_state_t  state, state_next;
  rrts_pkg::task_state_t tstate [N];
  rrts_pkg::task_state_t tstate_next [N];
  logic [N-1:0]  sleeping, sleeping_next;
  logic [N-1:0]  queued, queued_next;
  logic [TW-1:0] cur, cur_next;
  logic          cur_valid, cur_valid_next;
  logic [15:0]   slice_count, slice_count_next;
  logic [15:0]   slice_length;
  logic [63:0]   tick_counter, tick_counter_next;
  logic          sw_flag, sw_flag_next;
  logic          idle_flag, idle_flag_next;
  logic [SW-1:0] scan_cnt, scan_cnt_next;
  logic [TW-1:0] chk_idx, chk_idx_next;
  logic          chk_vld, chk_vld_next;

  rrts_pkg::req_t r_req;
  logic [3:0]     r_tid;
  logic [TW-1:0]  r_tidx;
  logic           r_from_user;
  logic [63:0]    r_wake;

  rrts_pkg::q_ctrl_t q_ctrl;
  rrts_pkg::q_stat_t q_stat;

  logic          wake_we;
  logic [63:0]   wake_rdata;
  logic          tid_ok;
  logic [15:0]   slice_inc;
  logic          have_next;
  logic [TW-1:0] nxt;
  logic [SW-1:0] cnt_after;

  assign busy   = (state != rrts_pkg::S_IDLE);
  assign r_tidx = TW'(r_tid);
  assign tid_ok = (32'(r_tid) < N);

  rrts_queue u_queue (
    .clk (clk),
    .rst (rst),
    .ctrl(q_ctrl),
    .stat(q_stat)
  );

  rrts_ram #(
    .WIDTH(64),
    .DEPTH(N)
  ) u_wake_ram (
    .clk  (clk),
    .we   (wake_we),
    .waddr(r_tidx),
    .wdata(r_wake),
    .raddr(scan_cnt[TW-1:0]),
    .rdata(wake_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrts_pkg::S_IDLE;
      sleeping     <= '0;
      queued       <= '0;
      cur          <= '0;
      cur_valid    <= 1'b0;
      slice_count  <= '0;
      slice_length <= rrts_pkg::SLICE_RESET;
      tick_counter <= '0;
      sw_flag      <= 1'b0;
      idle_flag    <= 1'b0;
      scan_cnt     <= '0;
      chk_idx      <= '0;
      chk_vld      <= 1'b0;
      done         <= 1'b0;
      for (int i = 0; i < N; i++) begin
        tstate[i] <= rrts_pkg::ST_FREE;
      end
    end else begin
      state        <= state_next;
      sleeping     <= sleeping_next;
      queued       <= queued_next;
      cur          <= cur_next;
      cur_valid    <= cur_valid_next;
      slice_count  <= slice_count_next;
      tick_counter <= tick_counter_next;
      sw_flag      <= sw_flag_next;
      idle_flag    <= idle_flag_next;
      scan_cnt     <= scan_cnt_next;
      chk_idx      <= chk_idx_next;
      chk_vld      <= chk_vld_next;
      done         <= (state == rrts_pkg::S_DONE);
      if (cfg_wen) begin
        slice_length <= cfg_wdata;
      end
      for (int i = 0; i < N; i++) begin
        tstate[i] <= tstate_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      r_req       <= rrts_pkg::req_t'(req_type);
      r_tid       <= task_id;
      r_from_user <= from_user;
      r_wake      <= wake_time;
    end
    if (state == rrts_pkg::S_DONE) begin
      run_task   <= cur_valid ? 4'(cur) : 4'd0;
      run_valid  <= cur_valid;
      switched   <= sw_flag;
      idle       <= idle_flag;
      tick_count <= tick_counter;
    end
  end

  always_comb begin
    state_next        = state;
    tstate_next       = tstate;
    sleeping_next     = sleeping;
    queued_next       = queued;
    cur_next          = cur;
    cur_valid_next    = cur_valid;
    slice_count_next  = slice_count;
    tick_counter_next = tick_counter;
    sw_flag_next      = sw_flag;
    idle_flag_next    = idle_flag;
    scan_cnt_next     = scan_cnt;
    chk_idx_next      = chk_idx;
    chk_vld_next      = chk_vld;
    q_ctrl            = '0;
    wake_we           = 1'b0;
    slice_inc         = slice_count + 16'd1;
    have_next         = (q_stat.count != '0);
    nxt               = q_stat.head_id;
    cnt_after         = have_next ? q_stat.count - 1'b1 : q_stat.count;

    unique case (state)
      rrts_pkg::S_IDLE: begin
        if (start) begin
          sw_flag_next   = 1'b0;
          idle_flag_next = 1'b0;
          unique case (rrts_pkg::req_t'(req_type))
            rrts_pkg::REQ_TICK: begin
              tick_counter_next = tick_counter + 64'd1;
              scan_cnt_next     = '0;
              chk_vld_next      = 1'b0;
              state_next        = rrts_pkg::S_SCAN;
            end
            rrts_pkg::REQ_YIELD: begin
              state_next = rrts_pkg::S_ROT_RD;
            end
            default: begin
              state_next = rrts_pkg::S_OP;
            end
          endcase
        end
      end

      rrts_pkg::S_SCAN: begin
        if (chk_vld && tstate[chk_idx] == rrts_pkg::ST_BLOCKED && sleeping[chk_idx] &&
            wake_rdata != 64'd0 && tick_counter >= wake_rdata) begin
          sleeping_next[chk_idx] = 1'b0;
          tstate_next[chk_idx]   = rrts_pkg::ST_READY;
          if (!queued[chk_idx] && 32'(q_stat.count) < N) begin
            q_ctrl.push          = 1'b1;
            q_ctrl.id            = chk_idx;
            queued_next[chk_idx] = 1'b1;
          end
        end
        if (scan_cnt == SW'(N)) begin
          chk_vld_next = 1'b0;
          state_next   = rrts_pkg::S_SLICE;
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
          chk_idx_next  = scan_cnt[TW-1:0];
          chk_vld_next  = 1'b1;
        end
      end

      rrts_pkg::S_SLICE: begin
        state_next = rrts_pkg::S_DONE;
        if (r_from_user && cur_valid && tstate[cur] == rrts_pkg::ST_RUNNING) begin
          slice_count_next = slice_inc;
          if (slice_inc >= slice_length) begin
            state_next = rrts_pkg::S_ROT_RD;
          end
        end
      end

      rrts_pkg::S_ROT_RD: begin
        state_next = rrts_pkg::S_ROT;
      end

      rrts_pkg::S_ROT: begin
        slice_count_next = '0;
        if (have_next) begin
          q_ctrl.pop       = 1'b1;
          queued_next[nxt] = 1'b0;
        end
        if (cur_valid && tstate[cur] == rrts_pkg::ST_RUNNING) begin
          tstate_next[cur] = rrts_pkg::ST_READY;
          if (!queued_next[cur] && 32'(cnt_after) < N) begin
            q_ctrl.push      = 1'b1;
            q_ctrl.id        = cur;
            queued_next[cur] = 1'b1;
          end
        end
        if (!have_next) begin
          idle_flag_next = 1'b1;
        end else begin
          tstate_next[nxt] = rrts_pkg::ST_RUNNING;
          if (!(cur_valid && cur == nxt)) begin
            cur_next       = nxt;
            cur_valid_next = 1'b1;
            sw_flag_next   = 1'b1;
          end
        end
        state_next = rrts_pkg::S_DONE;
      end

      rrts_pkg::S_OP: begin
        if (tid_ok) begin
          if (r_req == rrts_pkg::REQ_READY) begin
            if (tstate[r_tidx] != rrts_pkg::ST_RUNNING) begin
              tstate_next[r_tidx]   = rrts_pkg::ST_READY;
              sleeping_next[r_tidx] = 1'b0;
              if (!queued[r_tidx] && 32'(q_stat.count) < N) begin
                q_ctrl.push         = 1'b1;
                q_ctrl.id           = r_tidx;
                queued_next[r_tidx] = 1'b1;
              end
            end
          end else begin
            tstate_next[r_tidx]   = rrts_pkg::ST_BLOCKED;
            sleeping_next[r_tidx] = 1'b1;
            wake_we               = 1'b1;
          end
        end
        state_next = rrts_pkg::S_DONE;
      end

      rrts_pkg::S_DONE: begin
        state_next = rrts_pkg::S_IDLE;
      end

      default: begin
        state_next = rrts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/rrts_checker.sv
// Port-level checker for the round-robin task scheduler, attached by bind.
// Depends only on the ports of round_robin_task_scheduler.
`default_nettype none

module rrts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [3:0]  run_task,
  input wire logic        run_valid,
  input wire logic        switched,
  input wire logic        idle
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted transaction did not make the block busy.");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe while the block is busy.");

  a_switch_valid: assert property (@(posedge clk) disable iff (rst)
    done && switched |-> run_valid && !idle)
    else $error("Switch reported without a valid current task or with idle.");

  a_no_task_zero: assert property (@(posedge clk) disable iff (rst)
    done && !run_valid |-> run_task == 4'd0 && !switched)
    else $error("Task index reported without a current task.");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .run_task (run_task),
  .run_valid(run_valid),
  .switched (switched),
  .idle     (idle)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for round_robin_task_scheduler.
// Depends on rrts_pkg; a queue-fed driver, a predictor of the task table and a monitor
// check every result transaction field by field.
`default_nettype none

module tb_top;
  import rrts_pkg::*;

  localparam int IDLE_LIMIT = 500;
  localparam int CFG_SETTLE = 4;
  localparam int PHASE_REQS = 105;

  typedef enum logic [1:0] {
    PLAN_REQ,
    PLAN_CFG,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t  kind;
    req_t        req;
    logic [3:0]  tid;
    logic        user;
    logic [63:0] wake;
    logic [15:0] slice;
    logic        calm;
  } sched_item_t;

  typedef struct packed {
    logic [3:0]  run_task;
    logic        run_valid;
    logic        switched;
    logic        idle;
    logic [63:0] tick_count;
  } sched_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_TICK;
  logic [3:0]  task_id = 4'd0;
  logic        from_user = 1'b0;
  logic [63:0] wake_time = 64'd0;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        busy;
  logic        done;
  logic [3:0]  run_task;
  logic        run_valid;
  logic        switched;
  logic        idle;
  logic [63:0] tick_count;

  round_robin_task_scheduler u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .task_id    (task_id),
    .from_user  (from_user),
    .wake_time  (wake_time),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .run_task   (run_task),
    .run_valid  (run_valid),
    .switched   (switched),
    .idle       (idle),
    .tick_count (tick_count)
  );

  always #5 clk = ~clk;

  sched_item_t    req_plan_q[$];
  sched_outcome_t outcome_q[$];
  int             reqs_issued = 0;
  int             outcomes_seen = 0;
  int             errors = 0;
  int             idle_cycles = 0;
  logic           plan_calm = 1'b0;
  logic [63:0]    plan_ticks = 64'd0;

  task_state_t m_state[TASK_COUNT];
  logic        m_sleep[TASK_COUNT];
  logic [63:0] m_wake[TASK_COUNT];
  logic        m_queued[TASK_COUNT];
  logic [3:0]  m_fifo[TASK_COUNT];
  logic [3:0]  m_head;
  logic [3:0]  m_tail;
  logic [4:0]  m_count;
  logic [3:0]  m_cur;
  logic        m_cur_valid;
  logic [15:0] m_slice_cnt;
  logic [15:0] m_slice_len;
  logic [63:0] m_ticks;

  task automatic sched_reset();
    for (int i = 0; i < TASK_COUNT; i++) begin
      m_state[i] = ST_FREE;
      m_sleep[i] = 1'b0;
      m_wake[i] = 64'd0;
      m_queued[i] = 1'b0;
      m_fifo[i] = 4'd0;
    end
    m_head = 4'd0;
    m_tail = 4'd0;
    m_count = 5'd0;
    m_cur = 4'd0;
    m_cur_valid = 1'b0;
    m_slice_cnt = 16'd0;
    m_slice_len = SLICE_RESET;
    m_ticks = 64'd0;
  endtask

  task automatic ready_push(input logic [3:0] t);
    if (!m_queued[t] && m_count < 5'd16) begin
      m_fifo[m_tail] = t;
      m_tail = m_tail + 4'd1;
      m_count = m_count + 5'd1;
      m_queued[t] = 1'b1;
    end
  endtask

  task automatic ready_pop(output logic ok, output logic [3:0] t);
    ok = 1'b0;
    t = 4'd0;
    if (m_count != 5'd0) begin
      t = m_fifo[m_head];
      m_head = m_head + 4'd1;
      m_count = m_count - 5'd1;
      m_queued[t] = 1'b0;
      ok = 1'b1;
    end
  endtask

  task automatic rotate_tasks(inout logic sw, inout logic halt);
    logic       had_prev;
    logic       got_next;
    logic [3:0] prev;
    logic [3:0] nxt;
    had_prev = m_cur_valid;
    prev = m_cur;
    m_slice_cnt = 16'd0;
    ready_pop(got_next, nxt);
    if (had_prev && m_state[prev] == ST_RUNNING) begin
      m_state[prev] = ST_READY;
      ready_push(prev);
    end
    if (!got_next) begin
      halt = 1'b1;
    end else begin
      m_state[nxt] = ST_RUNNING;
      if (!(had_prev && prev == nxt)) begin
        m_cur = nxt;
        m_cur_valid = 1'b1;
        sw = 1'b1;
      end
    end
  endtask

  task automatic sched_apply(input sched_item_t it, output sched_outcome_t res);
    logic sw;
    logic halt;
    sw = 1'b0;
    halt = 1'b0;
    case (it.req)
      REQ_TICK: begin
        m_ticks = m_ticks + 64'd1;
        for (int i = 0; i < TASK_COUNT; i++) begin
          if (m_state[i] == ST_BLOCKED && m_sleep[i] && m_wake[i] != 64'd0 &&
              m_ticks >= m_wake[i]) begin
            m_sleep[i] = 1'b0;
            m_wake[i] = 64'd0;
            m_state[i] = ST_READY;
            ready_push(i[3:0]);
          end
        end
        if (it.user && m_cur_valid && m_state[m_cur] == ST_RUNNING) begin
          m_slice_cnt = m_slice_cnt + 16'd1;
          if (m_slice_cnt >= m_slice_len) rotate_tasks(sw, halt);
        end
      end
      REQ_READY: begin
        if (m_state[it.tid] != ST_RUNNING) begin
          m_state[it.tid] = ST_READY;
          m_sleep[it.tid] = 1'b0;
          m_wake[it.tid] = 64'd0;
          ready_push(it.tid);
        end
      end
      REQ_YIELD: begin
        rotate_tasks(sw, halt);
      end
      default: begin
        m_state[it.tid] = ST_BLOCKED;
        m_sleep[it.tid] = 1'b1;
        m_wake[it.tid] = it.wake;
      end
    endcase
    res.run_task = m_cur_valid ? m_cur : 4'd0;
    res.run_valid = m_cur_valid;
    res.switched = sw;
    res.idle = halt;
    res.tick_count = m_ticks;
  endtask

  task automatic add_req(input req_t r, input logic [3:0] t, input logic u,
                         input logic [63:0] w);
    sched_item_t it;
    it = '0;
    it.kind = PLAN_REQ;
    it.req = r;
    it.tid = t;
    it.user = u;
    it.wake = w;
    it.calm = plan_calm;
    req_plan_q.push_back(it);
    if (r == REQ_TICK) plan_ticks = plan_ticks + 64'd1;
  endtask

  task automatic add_marker(input plan_kind_t k, input logic [15:0] v);
    sched_item_t it;
    it = '0;
    it.kind = k;
    it.slice = v;
    req_plan_q.push_back(it);
  endtask

  // Driver: raises start for the head request and holds it until busy is low.
  int gap_left = 0;
  int settle = 0;

  always @(posedge clk) begin : drive_blk
    logic           launch;
    logic           nxt_start;
    logic           nxt_wen;
    sched_item_t    head;
    sched_item_t    cur_item;
    sched_outcome_t res;
    if (rst) begin
      start <= 1'b0;
      cfg_wen <= 1'b0;
    end else begin
      launch = start && !busy;
      nxt_start = start && !launch;
      nxt_wen = 1'b0;
      if (launch) begin
        cur_item = '0;
        cur_item.kind = PLAN_REQ;
        cur_item.req = req_t'(req_type);
        cur_item.tid = task_id;
        cur_item.user = from_user;
        cur_item.wake = wake_time;
        sched_apply(cur_item, res);
        outcome_q.push_back(res);
        reqs_issued++;
      end
      if (!nxt_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (req_plan_q.size() != 0) begin
          head = req_plan_q[0];
          case (head.kind)
            PLAN_REQ: begin
              if (!head.calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 10);
              end else begin
                void'(req_plan_q.pop_front());
                req_type <= head.req;
                task_id <= head.tid;
                from_user <= head.user;
                wake_time <= head.wake;
                nxt_start = 1'b1;
              end
            end
            PLAN_CFG: begin
              if (reqs_issued != outcomes_seen) begin
                settle = 0;
              end else if (settle < CFG_SETTLE) begin
                settle++;
              end else begin
                settle = 0;
                nxt_wen = 1'b1;
                cfg_wdata <= head.slice;
                m_slice_len = head.slice;
                void'(req_plan_q.pop_front());
              end
            end
            default: begin
              if (reqs_issued == outcomes_seen) void'(req_plan_q.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_wen <= nxt_wen;
    end
  end

  // Monitor: every result transaction is matched against the oldest prediction.
  always @(posedge clk) begin : watch_blk
    sched_outcome_t want;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        $error("result transaction with no request pending");
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (run_task !== want.run_task) begin
          $error("run_task: expected %0d, got %0d", want.run_task, run_task);
          errors++;
        end
        if (run_valid !== want.run_valid) begin
          $error("run_valid: expected %0d, got %0d", want.run_valid, run_valid);
          errors++;
        end
        if (switched !== want.switched) begin
          $error("switched: expected %0d, got %0d", want.switched, switched);
          errors++;
        end
        if (idle !== want.idle) begin
          $error("idle: expected %0d, got %0d", want.idle, idle);
          errors++;
        end
        if (tick_count !== want.tick_count) begin
          $error("tick_count: expected %0d, got %0d", want.tick_count, tick_count);
          errors++;
        end
      end
      outcomes_seen <= outcomes_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_wen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : plan_blk
    logic [15:0] slices[8];
    int          r;
    int          w;
    logic [3:0]  t;
    sched_reset();

    add_req(REQ_TICK, 4'd0, 1'b0, 64'd0);
    add_req(REQ_TICK, 4'd15, 1'b1, '1);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_READY, 4'd0, 1'b0, 64'd0);
    add_req(REQ_READY, 4'd15, 1'b0, 64'd0);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_READY, 4'd0, 1'b0, 64'd0);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_SLEEP, 4'd15, 1'b0, 64'd0);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_SLEEP, 4'd5, 1'b0, plan_ticks + 64'd2);
    add_req(REQ_TICK, 4'd0, 1'b0, 64'd0);
    add_req(REQ_TICK, 4'd0, 1'b0, 64'd0);
    add_req(REQ_SLEEP, 4'd5, 1'b0, '1);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);
    add_req(REQ_READY, 4'd15, 1'b0, 64'd0);
    add_marker(PLAN_CFG, 16'd2);
    add_req(REQ_TICK, 4'd0, 1'b1, 64'd0);
    add_req(REQ_TICK, 4'd0, 1'b1, 64'd0);
    add_req(REQ_SLEEP, 4'd7, 1'b0, 64'd1);
    add_req(REQ_TICK, 4'd0, 1'b0, 64'd0);
    add_req(REQ_SLEEP, 4'd3, 1'b0, 64'h8000_0000_0000_0000);
    add_req(REQ_YIELD, 4'd0, 1'b0, 64'd0);

    slices[0] = 16'd1;
    slices[1] = 16'hFFFF;
    slices[2] = 16'd4;
    slices[3] = 16'($urandom_range(1, 65535));
    slices[4] = 16'd2;
    slices[5] = 16'd10;
    slices[6] = 16'($urandom_range(1, 20));
    slices[7] = 16'd1;
    for (int p = 0; p < 8; p++) begin
      add_marker(PLAN_CFG, slices[p]);
      plan_calm = (p == 3 || p == 7);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) add_marker(PLAN_DRAIN, 16'd0);
        r = $urandom_range(0, 99);
        t = 4'($urandom_range(0, 15));
        if (r < 40) begin
          add_req(REQ_TICK, t, $urandom_range(0, 3) != 0, {$urandom, $urandom});
        end else if (r < 65) begin
          add_req(REQ_READY, t, 1'($urandom), {$urandom, $urandom});
        end else if (r < 78) begin
          add_req(REQ_YIELD, t, 1'($urandom), {$urandom, $urandom});
        end else begin
          w = $urandom_range(0, 19);
          if (w < 2) add_req(REQ_SLEEP, t, 1'($urandom), 64'd0);
          else if (w < 5) add_req(REQ_SLEEP, t, 1'($urandom),
                                  plan_ticks - 64'($urandom_range(0, 3)));
          else if (w < 16) add_req(REQ_SLEEP, t, 1'($urandom),
                                   plan_ticks + 64'($urandom_range(1, 12)));
          else add_req(REQ_SLEEP, t, 1'($urandom), {$urandom, $urandom});
        end
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (req_plan_q.size() != 0 || start || reqs_issued != outcomes_seen) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d predicted results never arrived", outcome_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
